// ----- hdl/ieu_pkg.sv -----
`timescale 1ns / 1ps

package ieu_pkg;

    localparam int unsigned XLEN      = 32;
    localparam int unsigned IDX_W     = 6;
    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [5:0] {
        OP_NOP     = 6'd0,
        OP_RETIRE  = 6'd1,
        OP_GET     = 6'd2,
        OP_PUT     = 6'd3,
        OP_CONST   = 6'd4,
        OP_MOV     = 6'd5,
        OP_ADD     = 6'd6,
        OP_SUB     = 6'd7,
        OP_AND     = 6'd8,
        OP_OR      = 6'd9,
        OP_XOR     = 6'd10,
        OP_SHL     = 6'd11,
        OP_SHR     = 6'd12,
        OP_SAR     = 6'd13,
        OP_SHLI    = 6'd14,
        OP_SHRI    = 6'd15,
        OP_SARI    = 6'd16,
        OP_NEG     = 6'd17,
        OP_NOT     = 6'd18,
        OP_BSWAP32 = 6'd19,
        OP_BSWAP16 = 6'd20,
        OP_HSWAP   = 6'd21,
        OP_CLZ     = 6'd22,
        OP_CTZ     = 6'd23,
        OP_POPCNT  = 6'd24,
        OP_BEXT    = 6'd25,
        OP_BSET    = 6'd26,
        OP_BCLR    = 6'd27,
        OP_BINV    = 6'd28,
        OP_SEXT8   = 6'd29,
        OP_SEXT16  = 6'd30,
        OP_ZEXT8   = 6'd31,
        OP_ZEXT16  = 6'd32,
        OP_SETF    = 6'd33,
        OP_GETCOND = 6'd34,
        OP_SELECT  = 6'd35,
        OP_SETPC   = 6'd36,
        OP_EXIT    = 6'd37,
        OP_EXIT_IF = 6'd38
    } op_t;

    typedef enum logic [3:0] {
        CC_EQ  = 4'd0,
        CC_NE  = 4'd1,
        CC_LT  = 4'd2,
        CC_GE  = 4'd3,
        CC_LTU = 4'd4,
        CC_GEU = 4'd5,
        CC_LE  = 4'd6,
        CC_GT  = 4'd7,
        CC_LEU = 4'd8,
        CC_GTU = 4'd9
    } cond_t;

    localparam logic [3:0] FSRC_ADD = 4'd0;
    localparam logic [3:0] FSRC_SUB = 4'd1;

    localparam logic [1:0] ST_EXEC  = 2'd0;
    localparam logic [1:0] ST_SKIP  = 2'd1;
    localparam logic [1:0] ST_UNSUP = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ZMASK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SMASK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VMASK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CMASK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZREN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ZRIDX = 3'd5;

    localparam logic [XLEN-1:0] SIGN_BIT = 32'h8000_0000;

    typedef struct packed {
        logic [5:0]       opcode;
        logic [IDX_W-1:0] src_a;
        logic             src_a_used;
        logic [IDX_W-1:0] src_b;
        logic             src_b_used;
        logic [IDX_W-1:0] dest;
        logic             dest_used;
        logic [XLEN-1:0]  immediate;
        logic [3:0]       aux;
        logic [3:0]       live_flags;
        logic             is_dead;
        logic             block_start;
    } ieu_req_t;

    typedef struct packed {
        logic [XLEN-1:0] value;
        logic            value_written;
        logic [XLEN-1:0] flags_word;
        logic [XLEN-1:0] program_counter;
        logic            exit_taken;
        logic [1:0]      status;
    } ieu_rsp_t;

    function automatic logic cond_eval(input logic [3:0] cc, input logic z, input logic s,
                                       input logic v, input logic c);
        logic res;
        res = 1'b1;
        case (cc)
            CC_EQ:   res = z;
            CC_NE:   res = !z;
            CC_LT:   res = s != v;
            CC_GE:   res = s == v;
            CC_LTU:  res = c;
            CC_GEU:  res = !c;
            CC_LE:   res = z || (s != v);
            CC_GT:   res = !z && (s == v);
            CC_LEU:  res = c || z;
            CC_GTU:  res = !c && !z;
            default: res = 1'b1;
        endcase
        return res;
    endfunction

    function automatic logic [5:0] clz32(input logic [XLEN-1:0] a);
        logic [5:0] n;
        n = 6'd32;
        for (int i = 0; i < 32; i++)
        begin
            if (a[i])
            begin
                n = 6'(31 - i);
            end
        end
        return n;
    endfunction

    function automatic logic [5:0] ctz32(input logic [XLEN-1:0] a);
        logic [5:0] n;
        n = 6'd32;
        for (int i = 31; i >= 0; i--)
        begin
            if (a[i])
            begin
                n = 6'(i);
            end
        end
        return n;
    endfunction

    function automatic logic [5:0] popcnt32(input logic [XLEN-1:0] a);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 0; i < 32; i++)
        begin
            n = n + 6'(a[i]);
        end
        return n;
    endfunction

endpackage

// ----- hdl/ieu_chan_if.sv -----
`timescale 1ns / 1ps

interface ieu_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/ieu_ram.sv -----
`timescale 1ns / 1ps

module ieu_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end
endmodule

// ----- hdl/ieu_alu.sv -----
`timescale 1ns / 1ps

module ieu_alu (
    input  logic [5:0]              opcode,
    input  logic [ieu_pkg::XLEN-1:0] a,
    input  logic [ieu_pkg::XLEN-1:0] b,
    input  logic [ieu_pkg::XLEN-1:0] imm,
    input  logic [ieu_pkg::XLEN-1:0] guest_rd,
    input  logic                    cond_ok,
    output logic [ieu_pkg::XLEN-1:0] result
);
    import ieu_pkg::*;

    logic [4:0]      sh_b;
    logic [4:0]      sh_i;
    logic [XLEN-1:0] bit_b;

    assign sh_b  = b[4:0];
    assign sh_i  = imm[4:0];
    assign bit_b = XLEN'(1) << sh_b;

    always_comb
    begin
        result = '0;
        case (op_t'(opcode))
            OP_GET:     result = guest_rd;
            OP_CONST:   result = imm;
            OP_MOV:     result = a;
            OP_ADD:     result = a + b;
            OP_SUB:     result = a - b;
            OP_AND:     result = a & b;
            OP_OR:      result = a | b;
            OP_XOR:     result = a ^ b;
            OP_SHL:     result = a << sh_b;
            OP_SHR:     result = a >> sh_b;
            OP_SAR:     result = XLEN'($signed(a) >>> sh_b);
            OP_SHLI:    result = a << sh_i;
            OP_SHRI:    result = a >> sh_i;
            OP_SARI:    result = XLEN'($signed(a) >>> sh_i);
            OP_NEG:     result = '0 - a;
            OP_NOT:     result = ~a;
            OP_BSWAP32: result = {a[7:0], a[15:8], a[23:16], a[31:24]};
            OP_BSWAP16: result = {a[23:16], a[31:24], a[7:0], a[15:8]};
            OP_HSWAP:   result = {a[15:0], a[31:16]};
            OP_CLZ:     result = XLEN'(clz32(a));
            OP_CTZ:     result = XLEN'(ctz32(a));
            OP_POPCNT:  result = XLEN'(popcnt32(a));
            OP_BEXT:    result = XLEN'(a[sh_b]);
            OP_BSET:    result = a | bit_b;
            OP_BCLR:    result = a & ~bit_b;
            OP_BINV:    result = a ^ bit_b;
            OP_SEXT8:   result = {{24{a[7]}}, a[7:0]};
            OP_SEXT16:  result = {{16{a[15]}}, a[15:0]};
            OP_ZEXT8:   result = {24'd0, a[7:0]};
            OP_ZEXT16:  result = {16'd0, a[15:0]};
            OP_GETCOND: result = XLEN'(cond_ok);
            OP_SELECT:  result = cond_ok ? a : b;
            default:    result = '0;
        endcase
    end
endmodule

// ----- hdl/ir_instruction_execute_unit.sv -----
`timescale 1ns / 1ps
// Pipeline: an accepted request is captured in the execute stage as its temporaries are
// read, then loads into the result register when the execute stage advances.
// Throughput: one request per cycle while the sink takes results; the execute stage
// advances whenever the result register is empty or being taken, so a stalled sink
// holds at most one extra request.
// Reset (rst_n, async low): guest registers, flags, pc, exit state and config clear.

module ir_instruction_execute_unit #(
    parameter int unsigned TEMP_COUNT      = 64,
    parameter int unsigned GUEST_REG_COUNT = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    ieu_chan_if.sink                          req,
    ieu_chan_if.source                        rsp,
    input  logic                              cfg_we,
    input  logic [ieu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ieu_pkg::XLEN-1:0]          cfg_wdata
);
    import ieu_pkg::*;

    localparam int unsigned TW = $clog2(TEMP_COUNT);
    localparam int unsigned GW = $clog2(GUEST_REG_COUNT);

    // Configuration
    logic [XLEN-1:0] zmask_reg, smask_reg, vmask_reg, cmask_reg;
    logic            zren_reg;
    logic [4:0]      zridx_reg;

    // Architectural state
    logic [XLEN-1:0] greg_reg [GUEST_REG_COUNT];
    logic [XLEN-1:0] flags_reg, flags_next;
    logic [XLEN-1:0] pc_reg, pc_next;
    logic            exited_reg, exited_next;

    // Execute stage: request register plus forwarding from the write that
    // landed in the temporary file on the same edge as our read.
    logic            s1_valid_reg;
    ieu_req_t        s1_reg;
    logic            fwd_a_reg, fwd_b_reg;
    logic [XLEN-1:0] fwd_data_reg;

    // Result register
    logic            out_valid_reg;
    ieu_rsp_t        out_reg, out_next;

    logic            advance;
    logic            accept;
    logic [XLEN-1:0] ram_a, ram_b;
    logic [XLEN-1:0] opa, opb;
    logic [XLEN-1:0] alu_r;
    logic [XLEN-1:0] guest_rd;
    logic            cond_ok;
    logic            exited_eff, skip, unsup, produces, written, exit_now;
    logic            greg_ok, put_en;
    logic [XLEN-1:0] target;

    assign advance   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || advance;
    assign accept    = req.valid && req.ready;

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zmask_reg <= '0;
            smask_reg <= '0;
            vmask_reg <= '0;
            cmask_reg <= '0;
            zren_reg  <= 1'b0;
            zridx_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ZMASK: zmask_reg <= cfg_wdata;
                CFG_SMASK: smask_reg <= cfg_wdata;
                CFG_VMASK: vmask_reg <= cfg_wdata;
                CFG_CMASK: cmask_reg <= cfg_wdata;
                CFG_ZREN:  zren_reg  <= cfg_wdata[0];
                CFG_ZRIDX: zridx_reg <= cfg_wdata[4:0];
                default:   ;
            endcase
        end
    end

    // Temporary file: read both operands on accept, write on advance.
    ieu_ram #(
        .WIDTH (XLEN),
        .DEPTH (TEMP_COUNT)
    ) u_temps (
        .clk     (clk),
        .we      (advance && written),
        .waddr   (TW'(s1_reg.dest)),
        .wdata   (alu_r),
        .re      (accept),
        .raddr_a (TW'(req.data.src_a)),
        .raddr_b (TW'(req.data.src_b)),
        .rdata_a (ram_a),
        .rdata_b (ram_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Capture the request and note whether the write retiring this edge
    // hits one of its operands (the memory returns the old word then).
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg       <= req.data;
            fwd_a_reg    <= advance && written && (s1_reg.dest == req.data.src_a);
            fwd_b_reg    <= advance && written && (s1_reg.dest == req.data.src_b);
            fwd_data_reg <= alu_r;
        end
    end

    // Operand selection: absent or out-of-range operands read zero.
    always_comb
    begin
        opa = '0;
        opb = '0;
        if (s1_reg.src_a_used && (32'(s1_reg.src_a) < TEMP_COUNT))
        begin
            opa = fwd_a_reg ? fwd_data_reg : ram_a;
        end
        if (s1_reg.src_b_used && (32'(s1_reg.src_b) < TEMP_COUNT))
        begin
            opb = fwd_b_reg ? fwd_data_reg : ram_b;
        end
    end

    // Guest register read for GET; the hard-wired zero register and
    // out-of-range indexes read zero and drop writes.
    assign greg_ok  = (s1_reg.immediate < GUEST_REG_COUNT)
                   && !(zren_reg && (s1_reg.immediate == XLEN'(zridx_reg)));
    assign guest_rd = greg_ok ? greg_reg[s1_reg.immediate[GW-1:0]] : '0;

    assign cond_ok = cond_eval(s1_reg.aux,
                               (flags_reg & zmask_reg) != '0,
                               (flags_reg & smask_reg) != '0,
                               (flags_reg & vmask_reg) != '0,
                               (flags_reg & cmask_reg) != '0);

    ieu_alu u_alu (
        .opcode   (s1_reg.opcode),
        .a        (opa),
        .b        (opb),
        .imm      (s1_reg.immediate),
        .guest_rd (guest_rd),
        .cond_ok  (cond_ok),
        .result   (alu_r)
    );

    // Control for the instruction in the execute stage
    always_comb
    begin
        logic [XLEN-1:0] fr;
        logic [3:0]      fval;
        logic [XLEN-1:0] fmask [4];
        logic            fsum_c;

        exited_eff = s1_reg.block_start ? 1'b0 : exited_reg;
        skip       = s1_reg.is_dead || exited_eff;
        unsup      = s1_reg.opcode > OP_EXIT_IF;
        target     = s1_reg.src_a_used ? opa : s1_reg.immediate;

        produces = !skip && !unsup;
        case (op_t'(s1_reg.opcode))
            OP_NOP, OP_RETIRE, OP_PUT, OP_SETF, OP_SETPC, OP_EXIT, OP_EXIT_IF:
                produces = 1'b0;
            default: ;
        endcase
        written = produces && s1_reg.dest_used && (32'(s1_reg.dest) < TEMP_COUNT);

        exit_now = !skip && ((s1_reg.opcode == OP_EXIT)
                   || ((s1_reg.opcode == OP_EXIT_IF) && cond_ok));
        put_en   = !skip && (s1_reg.opcode == OP_PUT) && greg_ok;

        pc_next = pc_reg;
        if (!skip && ((s1_reg.opcode == OP_SETPC) || exit_now))
        begin
            pc_next = target;
        end

        exited_next = exited_eff || (!skip && (exit_now || unsup));

        // Flag update: apply Z, S, V, C in order, each under its mask.
        fval   = '0;
        fsum_c = 1'b0;
        fr     = opa;
        if (s1_reg.aux == FSRC_ADD)
        begin
            {fsum_c, fr} = {1'b0, opa} + {1'b0, opb};
            fval[2] = ((~(opa ^ opb) & (opa ^ fr) & SIGN_BIT) != '0);
            fval[3] = fsum_c;
        end
        else if (s1_reg.aux == FSRC_SUB)
        begin
            fr = opa - opb;
            fval[2] = (((opa ^ opb) & (opa ^ fr) & SIGN_BIT) != '0);
            fval[3] = opa < opb;
        end
        fval[0] = fr == '0;
        fval[1] = fr[XLEN-1];
        fmask[0] = zmask_reg;
        fmask[1] = smask_reg;
        fmask[2] = vmask_reg;
        fmask[3] = cmask_reg;

        flags_next = flags_reg;
        if (!skip && (s1_reg.opcode == OP_SETF))
        begin
            for (int f = 0; f < 4; f++)
            begin
                if (s1_reg.live_flags[f])
                begin
                    flags_next = (flags_next & ~fmask[f]) | (fval[f] ? fmask[f] : '0);
                end
            end
        end

        out_next.value           = produces ? alu_r : '0;
        out_next.value_written   = written;
        out_next.flags_word      = flags_next;
        out_next.program_counter = pc_next;
        out_next.exit_taken      = exit_now;
        out_next.status          = skip ? ST_SKIP : (unsup ? ST_UNSUP : ST_EXEC);
    end

    // Commit architectural state when the instruction retires.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg  <= '0;
            pc_reg     <= '0;
            exited_reg <= 1'b0;
            for (int i = 0; i < GUEST_REG_COUNT; i++)
            begin
                greg_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            flags_reg  <= flags_next;
            pc_reg     <= pc_next;
            exited_reg <= exited_next;
            if (put_en)
            begin
                greg_reg[s1_reg.immediate[GW-1:0]] <= opa;
            end
        end
    end

    // Result register: load on advance, drop once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end
endmodule

// ----- hdl/ieu_checker.sv -----
`timescale 1ns / 1ps

module ieu_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      rsp_valid,
    input logic                      rsp_ready,
    input logic [ieu_pkg::XLEN-1:0]  value,
    input logic                      value_written,
    input logic                      exit_taken,
    input logic [1:0]                status
);
    import ieu_pkg::*;

    // Hold a result until taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    a_exit_exec: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && exit_taken |-> status == ST_EXEC)
        else $error("exit on non-executed instruction");

    a_write_exec: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && value_written |-> status == ST_EXEC)
        else $error("temporary written by non-executed instruction");

    a_skip_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_SKIP || status == ST_UNSUP) |-> value == '0)
        else $error("skipped instruction produced a value");
endmodule

bind ir_instruction_execute_unit ieu_checker u_ieu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .value         (rsp.data.value),
    .value_written (rsp.data.value_written),
    .exit_taken    (rsp.data.exit_taken),
    .status        (rsp.data.status)
);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import ieu_pkg::*;

    // Predicts each result by executing the instruction on a private copy of the
    // architectural state, then matches results in order.
    class exec_scoreboard;
        logic [31:0] temps [64];
        bit          temp_valid [64];
        logic [31:0] gregs [32];
        logic [31:0] flags;
        logic [31:0] pc;
        bit          exited;
        logic [31:0] fmask [4];
        bit          zr_en;
        logic [4:0]  zr_idx;
        ieu_rsp_t    expected_q [$];
        int          errors;
        int          checked;

        function new();
            foreach (temps[i])
            begin
                temps[i] = '0;
                temp_valid[i] = 0;
            end
            foreach (gregs[i])
            begin
                gregs[i] = '0;
            end
            foreach (fmask[i])
            begin
                fmask[i] = '0;
            end
            flags = '0;
            pc = '0;
            exited = 0;
            zr_en = 0;
            zr_idx = '0;
            errors = 0;
            checked = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
            case (idx)
                CFG_ZMASK: fmask[0] = v;
                CFG_SMASK: fmask[1] = v;
                CFG_VMASK: fmask[2] = v;
                CFG_CMASK: fmask[3] = v;
                CFG_ZREN:  zr_en = v[0];
                CFG_ZRIDX: zr_idx = v[4:0];
                default: ;
            endcase
        endfunction

        function bit cond_holds(logic [3:0] cc);
            bit z;
            bit s;
            bit v;
            bit c;
            z = (flags & fmask[0]) != 0;
            s = (flags & fmask[1]) != 0;
            v = (flags & fmask[2]) != 0;
            c = (flags & fmask[3]) != 0;
            case (cc)
                CC_EQ:  return z;
                CC_NE:  return !z;
                CC_LT:  return s != v;
                CC_GE:  return s == v;
                CC_LTU: return c;
                CC_GEU: return !c;
                CC_LE:  return z || (s != v);
                CC_GT:  return !z && (s == v);
                CC_LEU: return c || z;
                CC_GTU: return !c && !z;
                default: return 1;
            endcase
        endfunction

        function void update_flags(logic [31:0] x, logic [31:0] y, logic [3:0] src,
                                   logic [3:0] live);
            logic [31:0] r;
            bit          fv [4];
            if (live == 0)
                return;
            fv[2] = 0;
            fv[3] = 0;
            if (src == FSRC_ADD)
            begin
                r = x + y;
                fv[2] = ((~(x ^ y)) & (x ^ r) & SIGN_BIT) != 0;
                fv[3] = r < x;
            end
            else if (src == FSRC_SUB)
            begin
                r = x - y;
                fv[2] = ((x ^ y) & (x ^ r) & SIGN_BIT) != 0;
                fv[3] = x < y;
            end
            else
            begin
                r = x;
            end
            fv[0] = r == 0;
            fv[1] = r[31];
            for (int f = 0; f < 4; f++)
            begin
                if (live[f] && fmask[f] != 0)
                    flags = (flags & ~fmask[f]) | (fv[f] ? fmask[f] : 32'h0);
            end
        endfunction

        function bit greg_ok(logic [31:0] n);
            return n < 32 && !(zr_en && n == {27'h0, zr_idx});
        endfunction

        // Execute one accepted request and queue its expected result.
        function void note(ieu_req_t q);
            ieu_rsp_t    e;
            logic [31:0] a;
            logic [31:0] b;
            logic [31:0] target;
            logic [31:0] r;
            int          n;
            bit          produces;
            a = q.src_a_used ? temps[q.src_a] : 32'h0;
            b = q.src_b_used ? temps[q.src_b] : 32'h0;
            target = q.src_a_used ? a : q.immediate;
            r = '0;
            produces = 1;
            e = '0;
            if (q.block_start)
                exited = 0;
            if (q.is_dead || exited)
            begin
                e.status = ST_SKIP;
                produces = 0;
            end
            else
            begin
                e.status = ST_EXEC;
                case (q.opcode)
                    OP_NOP, OP_RETIRE: produces = 0;
                    OP_GET:     r = greg_ok(q.immediate) ? gregs[q.immediate[4:0]] : 32'h0;
                    OP_PUT:
                    begin
                        if (greg_ok(q.immediate))
                            gregs[q.immediate[4:0]] = a;
                        produces = 0;
                    end
                    OP_CONST:   r = q.immediate;
                    OP_MOV:     r = a;
                    OP_ADD:     r = a + b;
                    OP_SUB:     r = a - b;
                    OP_AND:     r = a & b;
                    OP_OR:      r = a | b;
                    OP_XOR:     r = a ^ b;
                    OP_SHL:     r = a << b[4:0];
                    OP_SHR:     r = a >> b[4:0];
                    OP_SAR:     r = $signed(a) >>> b[4:0];
                    OP_SHLI:    r = a << q.immediate[4:0];
                    OP_SHRI:    r = a >> q.immediate[4:0];
                    OP_SARI:    r = $signed(a) >>> q.immediate[4:0];
                    OP_NEG:     r = -a;
                    OP_NOT:     r = ~a;
                    OP_BSWAP32: r = {a[7:0], a[15:8], a[23:16], a[31:24]};
                    OP_BSWAP16: r = {a[23:16], a[31:24], a[7:0], a[15:8]};
                    OP_HSWAP:   r = {a[15:0], a[31:16]};
                    OP_CLZ:
                    begin
                        n = 0;
                        while (n < 32 && !a[31 - n])
                            n++;
                        r = n;
                    end
                    OP_CTZ:
                    begin
                        n = 0;
                        while (n < 32 && !a[n])
                            n++;
                        r = n;
                    end
                    OP_POPCNT:  r = $countones(a);
                    OP_BEXT:    r = {31'h0, a[b[4:0]]};
                    OP_BSET:    r = a | (32'h1 << b[4:0]);
                    OP_BCLR:    r = a & ~(32'h1 << b[4:0]);
                    OP_BINV:    r = a ^ (32'h1 << b[4:0]);
                    OP_SEXT8:   r = {{24{a[7]}}, a[7:0]};
                    OP_SEXT16:  r = {{16{a[15]}}, a[15:0]};
                    OP_ZEXT8:   r = {24'h0, a[7:0]};
                    OP_ZEXT16:  r = {16'h0, a[15:0]};
                    OP_SETF:
                    begin
                        update_flags(a, b, q.aux, q.live_flags);
                        produces = 0;
                    end
                    OP_GETCOND: r = cond_holds(q.aux) ? 32'h1 : 32'h0;
                    OP_SELECT:  r = cond_holds(q.aux) ? a : b;
                    OP_SETPC:
                    begin
                        pc = target;
                        produces = 0;
                    end
                    OP_EXIT:
                    begin
                        pc = target;
                        e.exit_taken = 1;
                        produces = 0;
                    end
                    OP_EXIT_IF:
                    begin
                        if (cond_holds(q.aux))
                        begin
                            pc = target;
                            e.exit_taken = 1;
                        end
                        produces = 0;
                    end
                    default:
                    begin
                        e.status = ST_UNSUP;
                        produces = 0;
                        exited = 1;
                    end
                endcase
                if (e.exit_taken)
                    exited = 1;
                if (produces && q.dest_used)
                begin
                    temps[q.dest] = r;
                    temp_valid[q.dest] = 1;
                    e.value_written = 1;
                end
                if (produces)
                    e.value = r;
            end
            e.flags_word = flags;
            e.program_counter = pc;
            expected_q.push_back(e);
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        task check(ieu_rsp_t g);
            ieu_rsp_t e;
            if (expected_q.size() == 0)
            begin
                report("result with no request outstanding");
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (g.value !== e.value)
                report($sformatf("value %h, want %h", g.value, e.value));
            if (g.value_written !== e.value_written)
                report($sformatf("value_written %b, want %b", g.value_written, e.value_written));
            if (g.flags_word !== e.flags_word)
                report($sformatf("flags_word %h, want %h", g.flags_word, e.flags_word));
            if (g.program_counter !== e.program_counter)
                report($sformatf("pc %h, want %h", g.program_counter, e.program_counter));
            if (g.exit_taken !== e.exit_taken)
                report($sformatf("exit_taken %b, want %b", g.exit_taken, e.exit_taken));
            if (g.status !== e.status)
                report($sformatf("status %0d, want %0d", g.status, e.status));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [XLEN-1:0] cfg_wdata;

    ieu_chan_if #(.payload_t(ieu_req_t)) req_if ();
    ieu_chan_if #(.payload_t(ieu_rsp_t)) rsp_if ();

    ir_instruction_execute_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if.sink),
        .rsp       (rsp_if.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    exec_scoreboard sb;
    int snd_idle;       // percent of cycles the sender holds off
    int rcv_idle;       // percent of cycles the receiver stalls
    int req_count;
    int stall_cycles;

    localparam int WATCHDOG_LIMIT = 5000;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Receiver: check on the rising edge, redraw ready on the falling edge.
    initial
    begin
        rsp_if.ready = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_if.valid && rsp_if.ready)
                sb.check(rsp_if.data);
            @(negedge clk);
            rsp_if.ready = $urandom_range(99) >= rcv_idle;
        end
    end

    // Watchdog: abort when nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
        @(negedge clk);
        cfg_we = 1;
        cfg_index = idx;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we = 0;
        sb.set_reg(idx, v);
    endtask

    task automatic write_all(logic [31:0] z, logic [31:0] s, logic [31:0] v, logic [31:0] c,
                             bit zen, logic [4:0] zidx);
        write_reg(CFG_ZMASK, z);
        write_reg(CFG_SMASK, s);
        write_reg(CFG_VMASK, v);
        write_reg(CFG_CMASK, c);
        write_reg(CFG_ZREN, {31'h0, zen});
        write_reg(CFG_ZRIDX, {27'h0, zidx});
    endtask

    // Hold until every expected result is back, then let the pipe settle.
    task automatic drain();
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_req(ieu_req_t q);
        while ($urandom_range(99) < snd_idle)
        begin
            @(negedge clk);
            req_if.valid = 0;
        end
        @(negedge clk);
        req_if.valid = 1;
        req_if.data = q;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        sb.note(q);
        req_count++;
    endtask

    function automatic ieu_req_t mk(op_t op, int sa, bit sau, int sbi, bit sbu, int d,
                                    logic [31:0] imm, logic [3:0] aux, logic [3:0] live,
                                    bit start);
        ieu_req_t q;
        q = '0;
        q.opcode = op;
        q.src_a = 6'(sa);
        q.src_a_used = sau;
        q.src_b = 6'(sbi);
        q.src_b_used = sbu;
        q.dest = 6'(d);
        q.dest_used = 1;
        q.immediate = imm;
        q.aux = aux;
        q.live_flags = live;
        q.block_start = start;
        return q;
    endfunction

    // Pick an operand: mostly a written temporary, sometimes absent.
    task automatic pick_src(output logic [5:0] idx, output logic used);
        int pool [$];
        foreach (sb.temp_valid[i])
        begin
            if (sb.temp_valid[i])
                pool.push_back(i);
        end
        idx = 6'($urandom_range(63));
        used = 0;
        if (pool.size() != 0 && $urandom_range(99) >= 12)
        begin
            idx = 6'(pool[$urandom_range(pool.size() - 1)]);
            used = 1;
        end
    endtask

    task automatic make_req(output ieu_req_t q);
        int sel;
        q = '0;
        sel = $urandom_range(99);
        if (sel < 15)
            q.opcode = OP_CONST;
        else if (sel < 19)
            q.opcode = 6'($urandom_range(63, 39));
        else
            q.opcode = 6'($urandom_range(38));
        pick_src(q.src_a, q.src_a_used);
        pick_src(q.src_b, q.src_b_used);
        q.dest = 6'($urandom_range(63));
        q.dest_used = $urandom_range(99) < 90;
        case ($urandom_range(4))
            0: q.immediate = $urandom_range(40);
            1:
            begin
                case ($urandom_range(3))
                    0: q.immediate = 32'h0;
                    1: q.immediate = 32'hFFFF_FFFF;
                    2: q.immediate = 32'h8000_0000;
                    default: q.immediate = 32'h7FFF_FFFF;
                endcase
            end
            4: q.immediate = {27'h0, sb.zr_idx};
            default: q.immediate = $urandom;
        endcase
        q.aux = 4'($urandom_range(15));
        q.live_flags = 4'($urandom_range(15));
        q.is_dead = $urandom_range(99) < 5;
        q.block_start = $urandom_range(99) < 15;
    endtask

    initial
    begin
        ieu_req_t q;
        ieu_req_t dir [$];
        sb = new();
        req_count = 0;
        snd_idle = 33;
        rcv_idle = 68;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_wdata = '0;
        req_if.valid = 0;
        req_if.data = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Distinct flag bits, register zero hard-wired.
        write_all(32'h4000_0000, 32'h8000_0000, 32'h1000_0000, 32'h2000_0000, 1, 5'd0);

        // Directed: operand extremes, flags, conditions, counts, guest regs, exits.
        dir.push_back(mk(OP_CONST, 0, 0, 0, 0, 0, 32'h0, 0, 0, 1));
        dir.push_back(mk(OP_CONST, 0, 0, 0, 0, 1, 32'hFFFF_FFFF, 0, 0, 0));
        dir.push_back(mk(OP_CONST, 0, 0, 0, 0, 2, 32'h8000_0000, 0, 0, 0));
        dir.push_back(mk(OP_CONST, 0, 0, 0, 0, 3, 32'h7FFF_FFFF, 0, 0, 0));
        dir.push_back(mk(OP_CONST, 0, 0, 0, 0, 4, 32'h1, 0, 0, 0));
        dir.push_back(mk(OP_ADD, 1, 1, 4, 1, 5, 0, 0, 0, 0));
        dir.push_back(mk(OP_SETF, 3, 1, 4, 1, 6, 0, FSRC_ADD, 4'hF, 0));
        dir.push_back(mk(OP_GETCOND, 0, 0, 0, 0, 7, 0, CC_LT, 0, 0));
        dir.push_back(mk(OP_SETF, 0, 1, 4, 1, 8, 0, FSRC_SUB, 4'hF, 0));
        dir.push_back(mk(OP_SELECT, 1, 1, 3, 1, 9, 0, CC_LTU, 0, 0));
        dir.push_back(mk(OP_SETF, 2, 1, 0, 0, 10, 0, 4'd7, 4'hC, 0));
        dir.push_back(mk(OP_SETF, 1, 1, 1, 1, 10, 0, FSRC_ADD, 4'h0, 0));
        dir.push_back(mk(OP_CLZ, 0, 1, 0, 0, 11, 0, 0, 0, 0));
        dir.push_back(mk(OP_CTZ, 0, 1, 0, 0, 12, 0, 0, 0, 0));
        dir.push_back(mk(OP_POPCNT, 1, 1, 0, 0, 13, 0, 0, 0, 0));
        dir.push_back(mk(OP_SAR, 2, 1, 1, 1, 14, 0, 0, 0, 0));
        dir.push_back(mk(OP_SEXT8, 1, 1, 0, 0, 15, 0, 0, 0, 0));
        dir.push_back(mk(OP_PUT, 1, 1, 0, 0, 0, 32'd5, 0, 0, 0));
        dir.push_back(mk(OP_PUT, 1, 1, 0, 0, 0, 32'd0, 0, 0, 0));
        dir.push_back(mk(OP_GET, 0, 0, 0, 0, 16, 32'd5, 0, 0, 0));
        dir.push_back(mk(OP_GET, 0, 0, 0, 0, 17, 32'd40, 0, 0, 0));
        dir.push_back(mk(OP_SETPC, 0, 0, 0, 0, 0, 32'h1234_5678, 0, 0, 0));
        dir.push_back(mk(OP_EXIT, 2, 1, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(OP_MOV, 1, 1, 0, 0, 18, 0, 0, 0, 0));
        q = mk(OP_EXIT_IF, 0, 0, 0, 0, 0, 32'hFFFF_FFFC, CC_GEU, 0, 1);
        dir.push_back(q);
        foreach (dir[i])
            send_req(dir[i]);
        q = mk(OP_MOV, 1, 1, 0, 0, 19, 0, 0, 0, 1);
        q.is_dead = 1;
        send_req(q);
        send_req(mk(op_t'(6'd50), 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // Pause the sender until every result is back.
        @(negedge clk);
        req_if.valid = 0;
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            drain();
            case (phase)
                0:
                begin
                    snd_idle = 33;
                    rcv_idle = 68;
                    write_all(32'h0, 32'h0, 32'h0, 32'h0, 0, 5'd31);
                end
                1:
                begin
                    snd_idle = 68;
                    rcv_idle = 33;
                    write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              1, 5'd31);
                end
                2:
                begin
                    snd_idle = 0;
                    rcv_idle = 0;
                    write_all(32'h0000_0040, 32'h0000_0080, 32'h0000_0800, 32'h0000_0001,
                              1, 5'd0);
                end
                default:
                begin
                    snd_idle = 0;
                    rcv_idle = 0;
                    write_all($urandom, $urandom, $urandom, $urandom, 1,
                              5'($urandom_range(31)));
                end
            endcase
            for (int k = 0; k < 138; k++)
            begin
                make_req(q);
                send_req(q);
            end
            @(negedge clk);
            req_if.valid = 0;
        end

        drain();
        repeat (10) @(posedge clk);
        $display("Ran %0d instructions over five flag/zero-register settings, %0d results checked.",
                 req_count, sb.checked);
        $display("Idling: sender and receiver stalls swapped, then back-to-back traffic.");
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
